@@ rtl/core/lru_key_value_cache_macros.svh @@
// Assertion macros for the LRU key-value cache.
// Used by the top level; needs a clock i_clk and reset i_rst_n in scope.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Condition must hold at every edge out of reset.
`define LKV_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lkv_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
// No dependencies.
package lkv_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request kinds
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic cmp_en;   // latch key compare result
        logic apply;    // shift chain this cycle
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

endpackage

@@ rtl/core/lkv_cell.sv @@
// One recency slot of the LRU chain: holds an entry, compares it against a key,
// loads its predecessor's entry on a shift. Depends on lkv_pkg.
module lkv_cell #(
    parameter int IDX         = 0,
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lkv_pkg::t_cell_ctl                 i_ctl,
    input  logic [lkv_pkg::KEY_W-1:0]          i_cmp_key,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]   i_shift_lim,
    input  lkv_pkg::t_entry                    i_prev,
    output lkv_pkg::t_entry                    o_entry,
    output logic                               o_match
);
    import lkv_pkg::*;

    localparam int CNTW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNTW-1:0] MY_POS = CNTW'(IDX);

    t_entry r_entry;
    logic   r_match;
    logic   w_load;

    // slots above the limit keep their entry
    assign w_load = i_ctl.apply && (MY_POS <= i_shift_lim);

    // key and value are not reset; the valid bit guards them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_match       <= 1'b0;
        end else begin
            if (w_load) begin
                r_entry <= i_prev;
            end
            if (i_ctl.cmp_en) begin
                r_match <= r_entry.valid && (r_entry.key == i_cmp_key);
            end
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: handshake, sequencer, cell chain.
// Depends on lkv_pkg, lkv_cell and lru_key_value_cache_macros.svh.
//
//  channel  | dir | handshake             | payload (low bits first)
//  ---------+-----+-----------------------+----------------------------------------
//  s_axis   | in  | tvalid / tready       | tdata: key, value; tuser: req_type
//  m_axis   | out | tvalid / tready       | tdata: read_value, evicted_key;
//           |     |                       | tuser: found, evicted
//  cfg      | in  | i_cfg_we              | i_cfg_wdata: capacity
//
// The accept edge latches the key compare in every cell; the commit edge in S_UPD
// shifts the chain and loads the output register.
// The update waits while the output register still holds an untaken word;
// the next word is accepted once the update has gone through.
// Synchronous active-low reset empties the chain and sets capacity to 16.
`include "lru_key_value_cache_macros.svh"
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,  // key[31:0], value[63:32]
    input  logic                       s_axis_tuser,  // req_type
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata,  // read_value[31:0], evicted_key[63:32]
    output logic [1:0]                 m_axis_tuser,  // found[0], evicted[1]
    input  logic                       i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]  i_cfg_wdata    // capacity
);
    import lkv_pkg::*;

    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CNTW = $clog2(MAX_ENTRIES + 1);
    localparam int EW   = (CNTW > CAP_W) ? CNTW : CAP_W;
    localparam logic [EW-1:0] MAX_EXT = EW'(MAX_ENTRIES);

    // chain state: cell 0 is most recent, valid cells form a prefix
    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_count, n_count;
    logic [CAP_W-1:0]  r_cap;

    // latched request
    logic              r_req_put;
    logic [KEY_W-1:0]  r_req_key;
    logic [VAL_W-1:0]  r_req_val;

    // output register
    logic              r_out_valid;
    logic              r_out_found, r_out_evicted;
    logic [VAL_W-1:0]  r_out_rdval;
    logic [KEY_W-1:0]  r_out_evkey;

    logic              w_accept, w_commit;
    t_cell_ctl         w_ctl;
    t_entry            w_ent   [MAX_ENTRIES];
    t_entry            w_new;
    logic [MAX_ENTRIES-1:0] w_match, w_valid;

    logic              w_found, w_evict;
    logic [IW-1:0]     w_hit_pos, w_old_pos;
    logic [VAL_W-1:0]  w_hit_val, w_rdval;
    logic [KEY_W-1:0]  w_evkey;
    logic [CNTW-1:0]   w_lim;
    logic [EW-1:0]     w_cap_ext, w_eff_cap, w_cnt_ext;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_UPD;
            S_UPD:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_commit      = 1'b0;
        unique case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_UPD:  w_commit      = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    // ---------------- lookup result ----------------
    always_comb begin
        w_hit_pos = '0;
        w_hit_val = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            // matches are one-hot, so OR-ing gives the single hit
            if (w_match[i]) begin
                w_hit_pos = w_hit_pos | IW'(i);
                w_hit_val = w_hit_val | w_ent[i].value;
            end
        end
    end

    assign w_found = |w_match;

    // effective capacity: zero counts as one, clamped to the chain length
    assign w_cap_ext = EW'(r_cap);
    assign w_cnt_ext = EW'(r_count);
    always_comb begin
        if (w_cap_ext == '0) begin
            w_eff_cap = EW'(1);
        end else if (w_cap_ext > MAX_EXT) begin
            w_eff_cap = MAX_EXT;
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end

    assign w_evict   = (r_req_put == REQ_PUT) && !w_found &&
                       ((w_cnt_ext >= w_eff_cap) || (w_cnt_ext >= MAX_EXT));
    // least recent entry sits at the end of the valid prefix
    assign w_old_pos = IW'(r_count - CNTW'(1));
    assign w_evkey   = w_ent[w_old_pos].key;

    // deepest slot that takes its neighbour's entry
    always_comb begin
        if (w_found) begin
            w_lim = CNTW'(w_hit_pos);
        end else if (w_evict) begin
            w_lim = r_count - CNTW'(1);
        end else begin
            w_lim = r_count;
        end
    end

    // entry entering at the head
    always_comb begin
        w_new.valid = 1'b1;
        w_new.key   = r_req_key;
        w_new.value = (r_req_put == REQ_PUT) ? r_req_val : w_hit_val;
    end

    assign w_rdval = (r_req_put == REQ_PUT) ? '0 : (w_found ? w_hit_val : '1);

    // get miss leaves the chain untouched
    assign w_ctl.cmp_en = w_accept;
    assign w_ctl.apply  = w_commit && (w_found || (r_req_put == REQ_PUT));

    always_comb begin
        n_count = r_count;
        if (w_commit && (r_req_put == REQ_PUT) && !w_found && !w_evict) begin
            n_count = r_count + CNTW'(1);
        end
    end

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_entry w_prev;
        if (g == 0) begin : g_head
            assign w_prev = w_new;
        end else begin : g_body
            assign w_prev = w_ent[g-1];
        end

        lkv_cell #(
            .IDX         (g),
            .MAX_ENTRIES (MAX_ENTRIES)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_cmp_key   (s_axis_tdata[KEY_W-1:0]),
            .i_shift_lim (w_lim),
            .i_prev      (w_prev),
            .o_entry     (w_ent[g]),
            .o_match     (w_match[g])
        );

        assign w_valid[g] = w_ent[g].valid;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_put <= s_axis_tuser;
            r_req_key <= s_axis_tdata[KEY_W-1:0];
            r_req_val <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        if (w_commit) begin
            r_out_found   <= w_found;
            r_out_evicted <= w_evict;
            r_out_rdval   <= w_rdval;
            r_out_evkey   <= w_evict ? w_evkey : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_evkey, r_out_rdval};
    assign m_axis_tuser  = {r_out_evicted, r_out_found};

    // ---------------- checks ----------------
    `LKV_ASSERT_ALWAYS(a_count_bound, (r_count <= CNTW'(MAX_ENTRIES)), "entry count over size")
    `LKV_ASSERT_ALWAYS(a_prefix_count, ($countones(w_valid) == int'(r_count)), "valid cells != count")
    `LKV_ASSERT_ALWAYS(a_hit_unique, (r_state != S_UPD || $onehot0(w_match)), "key held twice")
    `LKV_ASSERT_NEXT(a_accept_upd, w_accept, (r_state == S_UPD), "accept did not start update")

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for lru_key_value_cache: a shadow LRU store predicts each reply word.
// Depends on lkv_pkg and the lru_key_value_cache RTL; reads no files.
module testbench;
    import lkv_pkg::*;

    localparam int SLOTS     = MAX_ENTRIES_DEF;
    localparam int POOL_MAX  = 24;
    localparam int SETTLE    = 8;      // cycles after the last reply word
    localparam int DRAIN_CAP = 50000;  // cycles allowed for replies to drain

    typedef struct {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } t_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [63:0]        s_axis_tdata;  // key[31:0], value[63:32]
    logic               s_axis_tuser;  // req_type
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [63:0]        m_axis_tdata;  // read_value[31:0], evicted_key[63:32]
    logic [1:0]         m_axis_tuser;  // found[0], evicted[1]
    logic               i_cfg_we;
    logic [CAP_W-1:0]   i_cfg_wdata;   // capacity

    lru_key_value_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Shadow copy of the store; age 0 is the most recent live entry.
    logic [KEY_W-1:0] shadow_key  [SLOTS];
    logic [VAL_W-1:0] shadow_val  [SLOTS];
    logic             shadow_live [SLOTS];
    int               shadow_age  [SLOTS];
    int               shadow_count;
    int               shadow_cap;

    t_reply           replies_due[$];
    int               fail_count;

    // Traffic shaping, shared with the stall process
    int               src_idle_pct;
    int               snk_stall_pct;
    int               stall_request;
    int               stall_left;

    logic [KEY_W-1:0] key_pool [POOL_MAX];
    int               pool_size;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give-up limit, well above the slowest legal run.
    initial begin
        #8_000_000;
        $display("lru_key_value_cache verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void shadow_clear();
        for (int i = 0; i < SLOTS; i++) begin
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
            shadow_live[i] = 1'b0;
            shadow_age[i]  = 0;
        end
        shadow_count = 0;
        shadow_cap   = int'(CAP_RESET);
    endfunction

    // Slot s becomes most recent; anything younger ages by one.
    function automatic void shadow_touch(int s);
        int r;
        r = shadow_age[s];
        for (int i = 0; i < SLOTS; i++)
            if (shadow_live[i] && shadow_age[i] < r) shadow_age[i]++;
        shadow_age[s] = 0;
    endfunction

    function automatic t_reply lru_predict(logic kind, logic [KEY_W-1:0] k,
                                           logic [VAL_W-1:0] v);
        t_reply r;
        int     hit;
        int     slot;
        int     oldest;
        int     eff_cap;
        r.found       = 1'b0;
        r.read_value  = '0;
        r.evicted     = 1'b0;
        r.evicted_key = '0;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && shadow_live[i] && shadow_key[i] == k) hit = i;

        if (kind == REQ_GET) begin
            if (hit >= 0) begin
                r.found      = 1'b1;
                r.read_value = shadow_val[hit];
                shadow_touch(hit);
            end else begin
                r.read_value = '1;
            end
        end else if (hit >= 0) begin
            // update in place also refreshes recency
            r.found         = 1'b1;
            shadow_val[hit] = v;
            shadow_touch(hit);
        end else begin
            eff_cap = (shadow_cap < 1) ? 1 : (shadow_cap > SLOTS) ? SLOTS : shadow_cap;
            slot    = -1;
            // at or above capacity (also after a shrink): drop exactly one oldest
            if (shadow_count >= eff_cap) begin
                oldest = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (shadow_live[i] &&
                        (oldest < 0 || shadow_age[i] > shadow_age[oldest])) oldest = i;
                if (oldest >= 0) begin
                    r.evicted           = 1'b1;
                    r.evicted_key       = shadow_key[oldest];
                    shadow_live[oldest] = 1'b0;
                    shadow_count--;
                    slot = oldest;
                end
            end
            if (slot < 0)
                for (int i = 0; i < SLOTS; i++)
                    if (slot < 0 && !shadow_live[i]) slot = i;
            if (slot >= 0) begin
                for (int i = 0; i < SLOTS; i++)
                    if (shadow_live[i]) shadow_age[i]++;
                shadow_key[slot]  = k;
                shadow_val[slot]  = v;
                shadow_live[slot] = 1'b1;
                shadow_age[slot]  = 0;
                shadow_count++;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- driving

    // Offers one request word, idling first at the current rate; predicts on accept.
    task automatic push_request(input logic kind, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {v, k};
        s_axis_tuser  = kind;
        do @(posedge i_clk); while (!s_axis_tready);
        replies_due.push_back(lru_predict(kind, k, v));
    endtask

    // Drops valid, then waits for every outstanding reply word and a short settle.
    task automatic wait_for_idle();
        int guard;
        guard = 0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (replies_due.size() != 0 && guard < DRAIN_CAP) begin
            @(posedge i_clk);
            guard++;
        end
        if (replies_due.size() != 0) begin
            $display("%0t: replies missing, expected %0d more words, got none",
                     $time, replies_due.size());
            fail_count++;
            replies_due.delete();
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic set_capacity(input int cap);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = CAP_W'(cap);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        shadow_cap  = cap;
    endtask

    task automatic prepare_phase(input int cap, input int src_pct, input int snk_pct);
        wait_for_idle();
        set_capacity(cap);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        // a few more keys than entries, so hits and evictions both happen
        pool_size = (cap + cap / 2 + 2 > POOL_MAX) ? POOL_MAX : cap + cap / 2 + 2;
        for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom();
    endtask

    task automatic send_random(input int n);
        logic [KEY_W-1:0] k;
        logic             kind;
        for (int i = 0; i < n; i++) begin
            k    = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_size - 1)]
                                             : KEY_W'($urandom());
            kind = ($urandom_range(1) == 1) ? REQ_PUT : REQ_GET;
            push_request(kind, k, VAL_W'($urandom()));
        end
    endtask

    // Receiver: random stalls at the phase rate, plus long hold-offs on request.
    always @(negedge i_clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unrequested reply word, expected none, got %h/%h",
                         $time, m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("found", 32'(want.found), 32'(m_axis_tuser[0]));
                check_field("read_value", want.read_value, m_axis_tdata[31:0]);
                check_field("evicted", 32'(want.evicted), 32'(m_axis_tuser[1]));
                check_field("evicted_key", want.evicted_key, m_axis_tdata[63:32]);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Field extremes, keys differing only in the sign bit, updates that
    // refresh recency, eviction at capacity and a shrink below the count.
    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        push_request(REQ_GET, 32'h0000_0000, 32'h0);          // empty store: no match on 0
        push_request(REQ_PUT, 32'h8000_0000, 32'h7fff_ffff);
        push_request(REQ_GET, 32'h0000_0000, 32'hffff_ffff);  // sign bit only differs
        push_request(REQ_GET, 32'h8000_0000, 32'h0);
        push_request(REQ_PUT, 32'h7fff_ffff, 32'h8000_0000);
        push_request(REQ_PUT, 32'hffff_ffff, 32'hffff_ffff);
        push_request(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
        push_request(REQ_GET, 32'hffff_ffff, 32'h0);
        push_request(REQ_PUT, 32'h8000_0000, 32'h0000_0001);  // update
        push_request(REQ_GET, 32'h8000_0000, 32'h0);
        // shrink to one entry with four held: each insert drops one oldest
        wait_for_idle();
        set_capacity(1);
        push_request(REQ_PUT, 32'h1234_5678, 32'hdead_beef);
        push_request(REQ_PUT, 32'h5555_5555, 32'haaaa_aaaa);
        push_request(REQ_GET, 32'hffff_ffff, 32'h0);
        push_request(REQ_PUT, 32'haaaa_aaaa, 32'h5555_5555);
        push_request(REQ_GET, 32'h7fff_ffff, 32'h0);          // already gone
        // two entries, four still held: each insert drops one oldest, the update refreshes a1
        wait_for_idle();
        set_capacity(2);
        push_request(REQ_PUT, 32'h0000_00a1, 32'h11);
        push_request(REQ_PUT, 32'h0000_00b2, 32'h22);
        push_request(REQ_PUT, 32'h0000_00a1, 32'h33);
        push_request(REQ_PUT, 32'h0000_00c3, 32'h44);
        push_request(REQ_GET, 32'h0000_00b2, 32'h0);
        push_request(REQ_GET, 32'h0000_00a1, 32'h0);
        push_request(REQ_GET, 32'h0000_00c3, 32'h0);
    endtask

    task automatic test_streaming();
        prepare_phase(16, 0, 0);
        send_random(200);
        prepare_phase(1, 0, 0);
        send_random(150);
    endtask

    task automatic test_sender_gaps();
        prepare_phase(8, 81, 0);
        send_random(250);
    endtask

    task automatic test_receiver_stalls();
        prepare_phase(4, 0, 81);
        send_random(250);
    endtask

    task automatic test_mixed_idling();
        int caps [10] = '{16, 1, 15, 2, 5, 9, 3, 12, 7, 16};
        for (int i = 0; i < 10; i++) begin
            prepare_phase(caps[i], 10, 10);
            send_random(40);
        end
    endtask

    // Receiver held off long enough to back the block up into its input,
    // then the sender waits for every reply before carrying on.
    task automatic test_backpressure();
        prepare_phase(6, 0, 0);
        stall_request = 300;
        send_random(30);
        wait_for_idle();
        snk_stall_pct = 30;
        send_random(30);
    endtask

    // Fill all sixteen, then shrink: old entries linger and leave one per insert.
    task automatic test_capacity_shrink();
        prepare_phase(16, 0, 0);
        for (int i = 0; i < 16; i++) push_request(REQ_PUT, key_pool[i], VAL_W'($urandom()));
        wait_for_idle();
        set_capacity(3);
        pool_size     = 20;
        snk_stall_pct = 30;
        send_random(150);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_GET;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        stall_request = 0;
        stall_left    = 0;
        pool_size     = 1;
        fail_count    = 0;
        shadow_clear();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_backpressure();
        test_capacity_shrink();
        wait_for_idle();

        if (fail_count == 0) begin
            $display("lru_key_value_cache verification clean");
        end else begin
            $display("lru_key_value_cache verification failed");
        end
        $finish;
    end

endmodule
